// ----- src/eis_pkg.sv -----
// Shared types, constants and codes for the epipolar inlier scorer.
// No dependencies; every other file of the block imports this package.
package eis_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_F11_F12   = 3'd0,
        CFG_F13_F21   = 3'd1,
        CFG_F22_F23   = 3'd2,
        CFG_F31_F32   = 3'd3,
        CFG_F33       = 3'd4,
        CFG_INV_SIGMA = 3'd5
    } t_cfg_idx;

    // Field and datapath widths
    localparam int PT_W      = 16;
    localparam int COEF_W    = 32;
    localparam int INV_W     = 24;
    localparam int SCORE_W   = 32;
    localparam int LINE_W    = 46;   // line coefficient, signed Q.30
    localparam int E_W       = 64;   // point-line product, signed Q.34
    localparam int DEN_W     = 92;   // la^2 + lb^2
    localparam int ACC_W     = 128;  // shared accumulator
    localparam int MAC_X_W   = 64;
    localparam int MAC_Y_W   = 16;
    localparam int Q_W       = 40;   // distance, Q.16 square pixels
    localparam int FRAC_SH   = 8;
    localparam int DIV_SH    = Q_W - FRAC_SH;
    localparam int CHI_W     = 48;
    localparam int GAIN_W    = 19;

    // Thresholds and defaults
    localparam logic [SCORE_W-1:0] CHI_TH        = 32'd251724;  // 3.841 in Q16.16
    localparam logic [GAIN_W-1:0]  SCORE_K       = 19'd392626;  // 5.991 in Q16.16
    localparam int                 MIN_PAIRS     = 7;
    localparam int unsigned        MAX_PAIRS_DEF = 4096;
    localparam logic [INV_W-1:0]   INV_SIGMA_RST = 24'd65536;

    typedef struct packed {
        logic [PT_W-1:0] pt1_x;
        logic [PT_W-1:0] pt1_y;
        logic [PT_W-1:0] pt2_x;
        logic [PT_W-1:0] pt2_y;
        logic            first_pair;
        logic            last_pair;
    } t_pair_req;

    typedef struct packed {
        logic               is_inlier;
        logic [SCORE_W-1:0] running_score;
        logic               set_done;
        logic               too_few_pairs;
    } t_score_rsp;

    // One operation of the shared multiply-accumulate unit
    typedef struct packed {
        logic               en;
        logic               clr;
        logic               neg;
        logic [MAC_X_W-1:0] x;
        logic [MAC_Y_W-1:0] y;
        logic [1:0]         sh;
    } t_mac_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LINE,
        ST_EPT,
        ST_DEN,
        ST_NUM,
        ST_DIV,
        ST_CHI,
        ST_SCORE,
        ST_OUT
    } t_state;

endpackage

// ----- src/eis_req_if.sv -----
// Request channel of the epipolar inlier scorer: valid, ready and one point pair.
// Depends on eis_pkg.
interface eis_req_if;
    import eis_pkg::*;

    logic      valid;
    logic      ready;
    t_pair_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/eis_rsp_if.sv -----
// Response channel of the epipolar inlier scorer: valid, ready and one score.
// Depends on eis_pkg.
interface eis_rsp_if;
    import eis_pkg::*;

    logic       valid;
    logic       ready;
    t_score_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/epipolar_inlier_scorer_core.sv -----
// Epipolar inlier scorer: one point pair in, one score result out.
// Pairs are handled one at a time: a new request is taken only in the idle state, once the
//   previous result has moved into the output register. Each side uses the 40-step divider
//   and the shared 64x16 multiply-accumulate unit; a degenerate line skips the division and
//   a saturated distance ends it at its start.
// Reset: synchronous, active low; clears sequencer, score, pair count and matrix registers.
module epipolar_inlier_scorer_core #(
    parameter int unsigned MAX_PAIRS = eis_pkg::MAX_PAIRS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [eis_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [eis_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    eis_req_if.sink                        i_req,
    eis_rsp_if.source                      o_rsp
);
    import eis_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAIRS + 1);

    // Configuration registers
    logic [CFG_DATA_W-1:0] r_cfg_f11_f12;
    logic [CFG_DATA_W-1:0] r_cfg_f13_f21;
    logic [CFG_DATA_W-1:0] r_cfg_f22_f23;
    logic [CFG_DATA_W-1:0] r_cfg_f31_f32;
    logic [COEF_W-1:0]     r_cfg_f33;
    logic [INV_W-1:0]      r_inv;

    // Sequencer
    t_state     r_state, n_state;
    logic [1:0] r_j, n_j;        // term or chunk index
    logic [1:0] r_k, n_k;        // line coefficient index
    logic       r_side, n_side;  // 0: line in image 2, 1: line in image 1

    // Set state
    logic [SCORE_W-1:0] r_score;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_out_valid;

    // Per-pair payload
    t_pair_req                r_req;
    logic signed [LINE_W-1:0] r_line [3];
    logic signed [E_W-1:0]    r_e;
    logic [DEN_W-1:0]         r_den;
    logic [CHI_W-1:0]         r_chi;
    logic [1:0]               r_pass;
    t_score_rsp               r_out;

    // Datapath wires
    logic signed [COEF_W-1:0] w_f [3][3];
    logic signed [COEF_W-1:0] w_fsel;
    logic [PT_W-1:0]          w_pa_x, w_pa_y, w_pb_x, w_pb_y;
    logic signed [LINE_W-1:0] w_lsel;
    logic [LINE_W-1:0]        w_lsel_mag;
    logic signed [LINE_W-1:0] w_lden;
    logic [LINE_W+1:0]        w_lden_mag;
    logic [E_W-1:0]           w_e_mag;
    logic [COEF_W-1:0]        w_fsel_mag;
    t_mac_op                  w_mac_op;
    logic [ACC_W-1:0]         w_acc;
    logic [ACC_W-1:0]         w_acc_nxt;
    logic                     w_div_start;
    logic                     w_div_done;
    logic [Q_W-1:0]           w_div_q;
    logic                     w_den_zero;
    logic                     w_accept;
    logic                     w_out_free;
    logic                     w_chi_pass;
    logic [GAIN_W-1:0]        w_gain;
    logic [SCORE_W:0]         w_score_sum;
    logic [CNT_W-1:0]         w_cnt_inc;

    // Unpack the matrix; high half of each packed register holds the first entry
    always_comb begin
        w_f[0][0] = r_cfg_f11_f12[63:32];
        w_f[0][1] = r_cfg_f11_f12[31:0];
        w_f[0][2] = r_cfg_f13_f21[63:32];
        w_f[1][0] = r_cfg_f13_f21[31:0];
        w_f[1][1] = r_cfg_f22_f23[63:32];
        w_f[1][2] = r_cfg_f22_f23[31:0];
        w_f[2][0] = r_cfg_f31_f32[63:32];
        w_f[2][1] = r_cfg_f31_f32[31:0];
        w_f[2][2] = r_cfg_f33;
    end

    // Side 0 uses rows of F against p1, side 1 uses columns of F against p2
    always_comb begin
        w_pa_x     = r_side ? r_req.pt2_x : r_req.pt1_x;
        w_pa_y     = r_side ? r_req.pt2_y : r_req.pt1_y;
        w_pb_x     = r_side ? r_req.pt1_x : r_req.pt2_x;
        w_pb_y     = r_side ? r_req.pt1_y : r_req.pt2_y;
        w_fsel     = r_side ? w_f[r_j][r_k] : w_f[r_k][r_j];
        w_fsel_mag = w_fsel[COEF_W-1] ? (~w_fsel + COEF_W'(1)) : w_fsel;
        w_lsel     = r_line[r_j];
        w_lsel_mag = w_lsel[LINE_W-1] ? (~w_lsel + LINE_W'(1)) : w_lsel;
        w_lden     = r_k[0] ? r_line[1] : r_line[0];
        w_lden_mag = {2'b00, (w_lden[LINE_W-1] ? (~w_lden + LINE_W'(1)) : w_lden)};
        w_e_mag    = r_e[E_W-1] ? (~r_e + E_W'(1)) : r_e;
    end

    assign w_accept    = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_den_zero  = (w_acc_nxt[DEN_W-1:0] == '0);
    assign w_chi_pass  = (r_chi <= CHI_W'(CHI_TH));
    assign w_gain      = SCORE_K - r_chi[GAIN_W-1:0];
    assign w_score_sum = {1'b0, r_score} + (SCORE_W+1)'(w_gain);
    assign w_cnt_inc   = (r_cnt < CNT_W'(MAX_PAIRS)) ? (r_cnt + CNT_W'(1)) : r_cnt;

    // Next state
    always_comb begin
        n_state = r_state;
        n_j     = r_j;
        n_k     = r_k;
        n_side  = r_side;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_LINE;
                    n_j     = 2'd0;
                    n_k     = 2'd0;
                    n_side  = 1'b0;
                end
            end
            ST_LINE: begin
                if (r_j == 2'd2) begin
                    n_j = 2'd0;
                    if (r_k == 2'd2) begin
                        n_k     = 2'd0;
                        n_state = ST_EPT;
                    end else begin
                        n_k = r_k + 2'd1;
                    end
                end else begin
                    n_j = r_j + 2'd1;
                end
            end
            ST_EPT: begin
                if (r_j == 2'd2) begin
                    n_j     = 2'd0;
                    n_state = ST_DEN;
                end else begin
                    n_j = r_j + 2'd1;
                end
            end
            ST_DEN: begin
                if (r_j == 2'd2) begin
                    n_j = 2'd0;
                    if (r_k == 2'd1) begin
                        n_k = 2'd0;
                        if (w_den_zero) begin
                            // degenerate line: side fails, skip the division
                            n_state = r_side ? ST_OUT : ST_LINE;
                            n_side  = 1'b1;
                        end else begin
                            n_state = ST_NUM;
                        end
                    end else begin
                        n_k = 2'd1;
                    end
                end else begin
                    n_j = r_j + 2'd1;
                end
            end
            ST_NUM: begin
                if (r_j == 2'd3) begin
                    n_j     = 2'd0;
                    n_state = ST_DIV;
                end else begin
                    n_j = r_j + 2'd1;
                end
            end
            ST_DIV: begin
                if (r_j == 2'd0) begin
                    n_j = 2'd1;
                end else if (w_div_done) begin
                    n_j     = 2'd0;
                    n_state = ST_CHI;
                end
            end
            ST_CHI: begin
                if (r_j == 2'd1) begin
                    n_j     = 2'd0;
                    n_state = ST_SCORE;
                end else begin
                    n_j = r_j + 2'd1;
                end
            end
            ST_SCORE: begin
                n_state = r_side ? ST_OUT : ST_LINE;
                n_side  = 1'b1;
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: drive the shared unit and the divider start
    always_comb begin
        w_mac_op    = '0;
        w_div_start = 1'b0;
        case (r_state)
            ST_LINE: begin
                w_mac_op.en  = 1'b1;
                w_mac_op.clr = (r_j == 2'd0);
                w_mac_op.neg = w_fsel[COEF_W-1];
                w_mac_op.x   = MAC_X_W'(w_fsel_mag);
                w_mac_op.y   = (r_j == 2'd2) ? MAC_Y_W'(16) :
                               ((r_j == 2'd0) ? w_pa_x : w_pa_y);
            end
            ST_EPT: begin
                w_mac_op.en  = 1'b1;
                w_mac_op.clr = (r_j == 2'd0);
                w_mac_op.neg = w_lsel[LINE_W-1];
                w_mac_op.x   = MAC_X_W'(w_lsel_mag);
                w_mac_op.y   = (r_j == 2'd2) ? MAC_Y_W'(16) :
                               ((r_j == 2'd0) ? w_pb_x : w_pb_y);
            end
            ST_DEN: begin
                // square |la| then |lb| in 16-bit chunks
                w_mac_op.en  = 1'b1;
                w_mac_op.clr = (r_j == 2'd0) && (r_k == 2'd0);
                w_mac_op.x   = MAC_X_W'(w_lden_mag);
                w_mac_op.y   = w_lden_mag[r_j*MAC_Y_W +: MAC_Y_W];
                w_mac_op.sh  = r_j;
            end
            ST_NUM: begin
                w_mac_op.en  = 1'b1;
                w_mac_op.clr = (r_j == 2'd0);
                w_mac_op.x   = w_e_mag;
                w_mac_op.y   = w_e_mag[r_j*MAC_Y_W +: MAC_Y_W];
                w_mac_op.sh  = r_j;
            end
            ST_DIV: begin
                w_div_start = (r_j == 2'd0);
            end
            ST_CHI: begin
                w_mac_op.en  = 1'b1;
                w_mac_op.clr = (r_j == 2'd0);
                w_mac_op.x   = MAC_X_W'(w_div_q);
                w_mac_op.y   = r_j[0] ? MAC_Y_W'(r_inv[INV_W-1:MAC_Y_W])
                                      : r_inv[MAC_Y_W-1:0];
                w_mac_op.sh  = {1'b0, r_j[0]};
            end
            default: begin
                w_mac_op = '0;
            end
        endcase
    end

    assign i_req.ready = (r_state == ST_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    eis_mac u_mac (
        .i_clk     (i_clk),
        .i_op      (w_mac_op),
        .o_acc     (w_acc),
        .o_acc_nxt (w_acc_nxt)
    );

    eis_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_acc),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_q)
    );

    // Control state, set state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_j           <= 2'd0;
            r_k           <= 2'd0;
            r_side        <= 1'b0;
            r_score       <= '0;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
            r_cfg_f11_f12 <= '0;
            r_cfg_f13_f21 <= '0;
            r_cfg_f22_f23 <= '0;
            r_cfg_f31_f32 <= '0;
            r_cfg_f33     <= '0;
            r_inv         <= INV_SIGMA_RST;
        end else begin
            r_state <= n_state;
            r_j     <= n_j;
            r_k     <= n_k;
            r_side  <= n_side;

            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_F11_F12:   r_cfg_f11_f12 <= i_cfg_wdata;
                    CFG_F13_F21:   r_cfg_f13_f21 <= i_cfg_wdata;
                    CFG_F22_F23:   r_cfg_f22_f23 <= i_cfg_wdata;
                    CFG_F31_F32:   r_cfg_f31_f32 <= i_cfg_wdata;
                    CFG_F33:       r_cfg_f33     <= i_cfg_wdata[COEF_W-1:0];
                    CFG_INV_SIGMA: r_inv         <= i_cfg_wdata[INV_W-1:0];
                    default: begin
                        // drop writes beyond the register list
                    end
                endcase
            end

            // a new set starts clean
            if (w_accept && i_req.data.first_pair) begin
                r_score <= '0;
                r_cnt   <= '0;
            end

            // passing side adds (5.991 - chi), saturating
            if (r_state == ST_SCORE && w_chi_pass) begin
                r_score <= w_score_sum[SCORE_W] ? '1 : w_score_sum[SCORE_W-1:0];
            end

            if (r_state == ST_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
                if (r_req.last_pair) begin
                    r_score <= '0;
                    r_cnt   <= '0;
                end else begin
                    r_cnt <= w_cnt_inc;
                end
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Per-pair payload captures
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req.data;
        end
        if (r_state == ST_LINE && r_j == 2'd2) begin
            // floor to Q.30
            r_line[r_k] <= w_acc_nxt[LINE_W+3:4];
        end
        if (r_state == ST_EPT && r_j == 2'd2) begin
            r_e <= w_acc_nxt[E_W-1:0];
        end
        if (r_state == ST_DEN && r_j == 2'd2 && r_k == 2'd1) begin
            r_den <= w_acc_nxt[DEN_W-1:0];
            if (w_den_zero) begin
                r_pass[r_side] <= 1'b0;
            end
        end
        if (r_state == ST_CHI && r_j == 2'd1) begin
            r_chi <= w_acc_nxt[CHI_W+15:16];
        end
        if (r_state == ST_SCORE) begin
            r_pass[r_side] <= w_chi_pass;
        end
        if (r_state == ST_OUT && w_out_free) begin
            r_out.is_inlier     <= &r_pass;
            r_out.running_score <= r_score;
            r_out.set_done      <= r_req.last_pair;
            r_out.too_few_pairs <= r_req.last_pair && (w_cnt_inc <= CNT_W'(MIN_PAIRS));
        end
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_LINE && !r_side && r_j == 2'd0 && r_k == 2'd0))
        else $error("accepted pair did not start the first side");
    a_score_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCORE) |=> (r_score >= $past(r_score)))
        else $error("score decreased while scoring a side");
    a_few_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out.too_few_pairs || r_out.set_done))
        else $error("too-few flag outside set end");
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_PAIRS))
        else $error("pair count above cap");
`endif
endmodule

// ----- src/eis_mac.sv -----
// Shared multiply-accumulate unit: 64x16 product, shifted by 16-bit chunks.
// Depends on eis_pkg.
module eis_mac (
    input  logic                      i_clk,
    input  eis_pkg::t_mac_op          i_op,
    output logic [eis_pkg::ACC_W-1:0] o_acc,
    output logic [eis_pkg::ACC_W-1:0] o_acc_nxt
);
    import eis_pkg::*;

    logic [ACC_W-1:0]           r_acc;
    logic [MAC_X_W+MAC_Y_W-1:0] w_prod;
    logic [ACC_W-1:0]           w_shift;
    logic [ACC_W-1:0]           w_term;
    logic [ACC_W-1:0]           w_base;

    always_comb begin
        w_prod    = i_op.x * i_op.y;
        w_shift   = ACC_W'(w_prod) << {i_op.sh, 4'b0000};
        w_term    = i_op.neg ? (~w_shift + ACC_W'(1)) : w_shift;
        w_base    = i_op.clr ? '0 : r_acc;
        o_acc_nxt = w_base + w_term;
    end

    always_ff @(posedge i_clk) begin
        if (i_op.en) begin
            r_acc <= o_acc_nxt;
        end
    end

    assign o_acc = r_acc;
endmodule

// ----- src/eis_div.sv -----
// Restoring divider for floor(num * 2^8 / den), one quotient bit per cycle,
// saturating at all ones. Depends on eis_pkg.
module eis_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [eis_pkg::ACC_W-1:0] i_num,
    input  logic [eis_pkg::DEN_W-1:0] i_den,
    output logic                      o_done,
    output logic [eis_pkg::Q_W-1:0]   o_quot
);
    import eis_pkg::*;

    localparam int CNT_W = $clog2(Q_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [Q_W-1:0]   r_low;
    logic [Q_W-1:0]   r_q;

    logic             w_sat;
    logic [DEN_W:0]   w_sh;
    logic [DEN_W+1:0] w_dif;
    logic             w_ge;

    always_comb begin
        w_sat = i_num >= ACC_W'({i_den, {DIV_SH{1'b0}}});
        w_sh  = {r_rem, r_low[Q_W-1]};
        w_dif = {1'b0, w_sh} - {2'b00, i_den};
        w_ge  = !w_dif[DEN_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (w_sat) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CNT_W'(Q_W - 1);
                end
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[DIV_SH +: DEN_W];
            r_low <= {i_num[DIV_SH-1:0], {FRAC_SH{1'b0}}};
            r_q   <= w_sat ? '1 : '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_dif[DEN_W-1:0] : w_sh[DEN_W-1:0];
            r_low <= {r_low[Q_W-2:0], 1'b0};
            r_q   <= {r_q[Q_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held longer than one cycle");
    a_busy_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_done)
        else $error("divider done raised while still iterating");
`endif
endmodule

// ----- tb/epipolar_inlier_scorer_core_test.sv -----
// Self-checking testbench for epipolar_inlier_scorer_core: random handshakes, model-based check.
// Depends on eis_pkg, eis_req_if, eis_rsp_if and the core itself.
module epipolar_inlier_scorer_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import eis_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int LONG_HOLD      = 700;
    localparam int SETTLE_CYCLES  = 160;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    eis_req_if req_ch ();
    eis_rsp_if rsp_ch ();

    epipolar_inlier_scorer_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow copy of the block's registers and scoring state
    logic signed [31:0] fmat [3][3];
    logic [INV_W-1:0]   inv_sigma;
    logic [SCORE_W-1:0] score_acc;
    int unsigned        pair_cnt;

    t_pair_req  pending_pairs [$];
    t_score_rsp expected_scores [$];

    int  mismatch_cnt = 0;
    int  checked_cnt = 0;
    int  inlier_cnt = 0;
    int  set_cnt = 0;
    bit  burst_mode = 1'b0;     // sender and receiver insert no random gaps
    bit  long_hold_phase = 1'b0;
    int  idle_cycles = 0;

    // Append one pair to the send queue
    function automatic void add_pair(input t_pair_req p);
        pending_pairs.insert(pending_pairs.size(), p);
    endfunction

    // Floor of a signed value over 16
    function automatic logic signed [63:0] floor16(input logic signed [63:0] v);
        return v >>> 4;
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    // Score one side of a pair; true when the scaled distance passes
    function automatic bit score_side(input logic signed [63:0] la, input logic signed [63:0] lb,
                                      input logic signed [63:0] err);
        logic [127:0] den;
        logic [127:0] num;
        logic [135:0] quo;
        logic [63:0]  d_sq;
        logic [63:0]  chi;
        logic [63:0]  sum;
        den = 128'(abs64(la)) * 128'(abs64(la)) + 128'(abs64(lb)) * 128'(abs64(lb));
        if (den == 0)
            return 1'b0;
        num = 128'(abs64(err)) * 128'(abs64(err));
        quo = {num, 8'h00} / 136'(den);
        d_sq = (quo > 136'(40'hFF_FFFF_FFFF)) ? 64'hFF_FFFF_FFFF : 64'(quo);
        chi = (d_sq * 64'(inv_sigma)) >> 16;
        if (chi > 64'(CHI_TH))
            return 1'b0;
        sum = 64'(score_acc) + (64'(SCORE_K) - chi);
        score_acc = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
        return 1'b1;
    endfunction

    // Work out the score result of one pair and advance the set state
    function automatic t_score_rsp predict_score(input t_pair_req p);
        t_score_rsp r;
        logic signed [63:0] u1, v1, u2, v2, la, lb, lc, err;
        logic signed [63:0] f [3][3];
        bit pass1, pass2;
        u1 = 64'(p.pt1_x); v1 = 64'(p.pt1_y);
        u2 = 64'(p.pt2_x); v2 = 64'(p.pt2_y);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                f[i][j] = 64'(fmat[i][j]);
        if (p.first_pair) begin
            score_acc = '0;
            pair_cnt = 0;
        end
        // Line in image 2 from the first point
        la = floor16(f[0][0] * u1 + f[0][1] * v1 + f[0][2] * 16);
        lb = floor16(f[1][0] * u1 + f[1][1] * v1 + f[1][2] * 16);
        lc = floor16(f[2][0] * u1 + f[2][1] * v1 + f[2][2] * 16);
        err = u2 * la + v2 * lb + lc * 16;
        pass1 = score_side(la, lb, err);
        // Line in image 1 from the second point
        la = floor16(u2 * f[0][0] + v2 * f[1][0] + f[2][0] * 16);
        lb = floor16(u2 * f[0][1] + v2 * f[1][1] + f[2][1] * 16);
        lc = floor16(u2 * f[0][2] + v2 * f[1][2] + f[2][2] * 16);
        err = u1 * la + v1 * lb + lc * 16;
        pass2 = score_side(la, lb, err);
        if (pair_cnt < MAX_PAIRS_DEF)
            pair_cnt++;
        r.is_inlier = pass1 && pass2;
        r.running_score = score_acc;
        r.set_done = p.last_pair;
        r.too_few_pairs = 1'b0;
        if (p.last_pair) begin
            r.too_few_pairs = pair_cnt <= MIN_PAIRS;
            score_acc = '0;
            pair_cnt = 0;
        end
        return r;
    endfunction

    // Request driver: pop the next pair, draw a gap after every accepted request
    int req_gap = 0;
    always @(posedge i_clk) begin
        bit taken;
        taken = req_ch.valid && req_ch.ready;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (taken) begin
                expected_scores.insert(expected_scores.size(), predict_score(req_ch.data));
                req_gap = burst_mode ? 0 : $urandom_range(0, 19);
            end
            if (!req_ch.valid || taken) begin
                if (req_gap > 0) begin
                    req_gap--;
                    req_ch.valid <= 1'b0;
                end else if (pending_pairs.size() > 0) begin
                    req_ch.data <= pending_pairs.pop_front();
                    req_ch.valid <= 1'b1;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
    end

    // Response monitor: random back-pressure, one long hold-off, field-by-field check
    int  rsp_gap = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    always @(posedge i_clk) begin
        t_score_rsp want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                checked_cnt++;
                if (rsp_ch.data.is_inlier) inlier_cnt++;
                if (rsp_ch.data.set_done) set_cnt++;
                if (expected_scores.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("ERROR: unexpected result %p", rsp_ch.data);
                end else begin
                    want = expected_scores.pop_front();
                    if (rsp_ch.data.is_inlier !== want.is_inlier ||
                        rsp_ch.data.running_score !== want.running_score ||
                        rsp_ch.data.set_done !== want.set_done ||
                        rsp_ch.data.too_few_pairs !== want.too_few_pairs) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("ERROR: result %0d expected %p got %p",
                                     checked_cnt, want, rsp_ch.data);
                    end
                end
                rsp_gap = burst_mode ? 0 : $urandom_range(0, 19);
            end
            // Hold off for a long stretch once so that the core backs up
            if (long_hold_phase && !hold_done && hold_left == 0)
                hold_left = LONG_HOLD;
            if (hold_left > 0) begin
                hold_left--;
                if (hold_left == 0) hold_done = 1'b1;
                rsp_ch.ready <= 1'b0;
            end else if (rsp_gap > 0) begin
                rsp_gap--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (i_rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: watchdog expired with %0d results outstanding",
                     expected_scores.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Write one register and update the shadow copy
    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_F11_F12: begin fmat[0][0] = value[63:32]; fmat[0][1] = value[31:0]; end
            CFG_F13_F21: begin fmat[0][2] = value[63:32]; fmat[1][0] = value[31:0]; end
            CFG_F22_F23: begin fmat[1][1] = value[63:32]; fmat[1][2] = value[31:0]; end
            CFG_F31_F32: begin fmat[2][0] = value[63:32]; fmat[2][1] = value[31:0]; end
            CFG_F33:     fmat[2][2] = value[31:0];
            CFG_INV_SIGMA: inv_sigma = value[INV_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_matrix(input logic [31:0] m [9], input logic [63:0] inv);
        write_reg(CFG_F11_F12, {m[0], m[1]});
        write_reg(CFG_F13_F21, {m[2], m[3]});
        write_reg(CFG_F22_F23, {m[4], m[5]});
        write_reg(CFG_F31_F32, {m[6], m[7]});
        write_reg(CFG_F33, {$urandom(), m[8]});   // upper bits are ignored
        write_reg(CFG_INV_SIGMA, inv);
    endtask

    // Hold until every queued pair is sent and every result is back
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_pairs.size() > 0 || expected_scores.size() > 0 || req_ch.valid);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_pair_req gen_pair(input int kind, input bit first, input bit last);
        t_pair_req p;
        int dy, dx;
        p.pt1_x = $urandom();
        p.pt1_y = $urandom();
        // Near-matched rows for kind 0, fully random otherwise
        dy = $urandom_range(0, 80) - 40;
        dx = $urandom_range(0, 2000) - 1000;
        if (kind == 0) begin
            p.pt2_x = p.pt1_x + 16'(dx);
            p.pt2_y = p.pt1_y + 16'(dy);
        end else begin
            p.pt2_x = $urandom();
            p.pt2_y = $urandom();
        end
        p.first_pair = first;
        p.last_pair = last;
        return p;
    endfunction

    // Queue well-formed sets with some stray pairs and broken framing mixed in
    task automatic queue_sets(input int n_items, input int kind);
        int left, len;
        left = n_items;
        while (left > 0) begin
            if ($urandom_range(0, 9) == 0) begin
                add_pair(gen_pair(kind, $urandom(), $urandom()));
                left--;
            end else begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(6, 24);
                for (int k = 0; k < len; k++)
                    add_pair(gen_pair(kind, k == 0, k == len - 1));
                left -= len;
            end
        end
    endtask

    logic [31:0] rect_f [9];
    logic [31:0] rand_f [9];
    logic [63:0] inv_pick;
    int          mode;
    initial begin
        rect_f = '{0, 0, 0, 0, 0, 32'hC000_0000, 0, 32'h4000_0000, 0};
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                fmat[i][j] = '0;
        inv_sigma = INV_SIGMA_RST;
        score_acc = '0;
        pair_cnt = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset matrix is all zero: every line is degenerate and nothing scores
        add_pair('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0});
        add_pair('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1});
        wait_drained();

        // Rectified pair geometry: inliers when rows match
        load_matrix(rect_f, 64'h0001_0000);
        add_pair('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0});
        add_pair('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0});
        add_pair('{16'h0100, 16'h0200, 16'h0300, 16'h0220, 1'b0, 1'b0});
        add_pair('{16'h0100, 16'h0200, 16'h0300, 16'h0240, 1'b0, 1'b0});
        add_pair('{16'h0100, 16'hFFFF, 16'h0300, 16'h0000, 1'b0, 1'b1});
        // Set of exactly eight pairs, then one of seven that runs on without a first flag
        for (int k = 0; k < 8; k++)
            add_pair(gen_pair(0, k == 0, k == 7));
        for (int k = 0; k < 7; k++)
            add_pair(gen_pair(0, 1'b0, k == 6));
        add_pair('{16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 1'b1, 1'b1});
        wait_drained();

        // Random phases over a spread of matrices and noise gains
        for (int ph = 0; ph < 14; ph++) begin
            mode = ph % 5;
            case (mode)
                0, 1: rand_f = rect_f;
                2: for (int i = 0; i < 9; i++) rand_f[i] = $urandom();
                3: for (int i = 0; i < 9; i++)
                       rand_f[i] = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                default: for (int i = 0; i < 9; i++)
                       rand_f[i] = rect_f[i] + 32'($urandom_range(0, 4096)) - 32'd2048;
            endcase
            case (ph % 4)
                0: inv_pick = {$urandom(), 32'h0000_0000};      // zero gain, upper bits set
                1: inv_pick = 64'h0000_0000_00FF_FFFF;
                2: inv_pick = 64'($urandom_range(0, 24'hFF_FFFF));
                default: inv_pick = 64'($urandom_range(16384, 262144));
            endcase
            load_matrix(rand_f, inv_pick);
            burst_mode = (ph % 6 == 5);
            long_hold_phase = (ph == 7);
            if (ph == 7)
                burst_mode = 1'b1;
            queue_sets(75, (mode == 2 || mode == 3) ? 1 : ($urandom_range(0, 4) == 0));
            wait_drained();
            long_hold_phase = 1'b0;
        end
        burst_mode = 1'b0;

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_scores.size() > 0) begin
            mismatch_cnt++;
            $display("ERROR: %0d results never arrived", expected_scores.size());
        end
        $display("Coverage: %0d pair results checked, %0d inliers, %0d completed sets,",
                 checked_cnt, inlier_cnt, set_cnt);
        $display("  14 register settings incl. degenerate, extreme and zero/full gain; %0d errors",
                 mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
